>>> design/lzw_vwd_pkg.sv
// Shared constants and types for the variable width LZW decoder.
package lzw_vwd_pkg;

  // Default of the widest code
  localparam int unsigned MAX_CODE_BITS_DEF = 12;

  // Bit buffer, width of its fill counter and push limit
  localparam int unsigned BUF_BITS   = 24;
  localparam int unsigned BUF_CNT_W  = 5;
  localparam int unsigned PUSH_LIMIT = 16;

  // Reserved codes and code width at start
  localparam int unsigned START_WIDTH = 9;
  localparam int unsigned CLEAR_CODE  = 'h100;
  localparam int unsigned END_CODE    = 'h101;
  localparam int unsigned FIRST_FREE  = 'h102;

  // Request kinds on the input stream
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  // Decoder status codes
  typedef enum logic [1:0] {
    STAT_RUN       = 2'd0,
    STAT_NEED_BITS = 2'd1,
    STAT_END       = 2'd2,
    STAT_ERROR     = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_DECODE,
    ST_WALK,
    ST_FINISH
  } state_e;

endpackage

>>> design/lzw_variable_width_decoder.sv
// Variable width LZW decoder: bit buffer, dictionary, string stack and sequencer.
//
// Usage: every input request is one of two kinds, selected by s_axis_tuser_i.
// A push (0) offers one compressed byte in s_axis_tdata_i; it is taken into the
// 24-bit bit buffer when at most 16 bits are buffered, else refused. A pull (1)
// returns the next decoded byte. Each request yields exactly one response on the
// m_axis side carrying the byte, its valid flag, the push-taken flag and status.
// Codes are 9 bits after reset or a clear code and grow up to MaxCodeBits bits.
// Timing: a push, or a pull that only reports a sticky status, answers in the
// cycle after acceptance. A pull from a filled string stack passes through the
// pop state for the registered stack read. A pull that decodes a code passes
// the decode state once per clear code consumed and once for the code, the walk
// state once per character of its string walked through the dictionary port, and
// the finish state; the bytes of that string are then pulled from the stack through
// the pop state. The single dictionary read port, one entry per cycle, sets the decode time.
// The block takes one request at a time; s_axis_tready_o is low while a request
// is being worked on, and also while a response waits and m_axis_tready_i is low.
// Reset clears the bit buffer, the stack level and the status; the dictionary
// and stack memories are not cleared and are always written before being read.
module lzw_variable_width_decoder #(
  parameter int unsigned MaxCodeBits = lzw_vwd_pkg::MAX_CODE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [7:0] out_byte, [8] out_valid,
                                        // [9] byte_taken, [11:10] status
);
  import lzw_vwd_pkg::*;

  localparam int unsigned DictDepth = 1 << MaxCodeBits;
  localparam int unsigned LevelW    = MaxCodeBits + 1;
  localparam int unsigned WidthW    = $clog2(MaxCodeBits + 1);

  localparam logic [MaxCodeBits-1:0] CodeClear = MaxCodeBits'(CLEAR_CODE);
  localparam logic [MaxCodeBits-1:0] CodeEnd   = MaxCodeBits'(END_CODE);
  localparam logic [LevelW-1:0]      FreeStart = LevelW'(FIRST_FREE);
  localparam logic [WidthW-1:0]      WidthStart = WidthW'(START_WIDTH);
  localparam logic [WidthW-1:0]      WidthMax   = WidthW'(MaxCodeBits);

  // Memories
  logic [MaxCodeBits-1:0] prefix_mem [DictDepth];
  logic [7:0]             suffix_mem [DictDepth];
  logic [7:0]             stack_mem  [DictDepth];

  // Control and datapath registers
  state_e                 state_q, state_d;
  logic [BUF_BITS-1:0]    bit_buf_q, bit_buf_d;
  logic [BUF_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [WidthW-1:0]      code_width_q, code_width_d;
  logic [LevelW-1:0]      nfc_q, nfc_d;
  logic [MaxCodeBits-1:0] prev_q, prev_d;
  logic                   lit_pend_q, lit_pend_d;
  status_e                dec_status_q, dec_status_d;
  logic [LevelW-1:0]      level_q, level_d;
  logic [MaxCodeBits-1:0] cur_q, cur_d;
  logic [MaxCodeBits-1:0] code_q, code_d;
  logic                   special_q, special_d;
  logic [7:0]             first_q, first_d;

  // Response register
  logic                   m_valid_q, m_valid_d;
  logic [7:0]             out_byte_q, out_byte_d;
  logic                   out_valid_q, out_valid_d;
  logic                   taken_q, taken_d;
  logic [1:0]             status_q, status_d;

  // Memory ports
  logic [MaxCodeBits-1:0] prefix_rd_q;
  logic [7:0]             suffix_rd_q;
  logic [7:0]             stack_rd_q;
  logic [MaxCodeBits-1:0] dict_raddr;
  logic                   dict_we;
  logic                   stk_we;
  logic [MaxCodeBits-1:0] stk_waddr;
  logic [7:0]             stk_wdata;
  logic [MaxCodeBits-1:0] stk_raddr;

  // Shared helpers
  logic                   s_ready;
  logic                   s_accept;
  logic [LevelW-1:0]      level_dec;
  logic [LevelW-1:0]      level_inc;
  logic [LevelW-1:0]      nfc_inc;
  logic [BUF_BITS-1:0]    code_mask;
  logic [BUF_BITS-1:0]    code_full;
  logic [MaxCodeBits-1:0] code;
  logic                   stack_full;

  assign s_ready   = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign s_accept  = s_axis_tvalid_i && s_ready;
  assign level_dec = level_q - LevelW'(1);
  assign level_inc = level_q + LevelW'(1);
  assign nfc_inc   = nfc_q + LevelW'(1);
  assign stk_raddr = level_dec[MaxCodeBits-1:0];
  assign stack_full = level_q[MaxCodeBits];

  // Extract the next code by masking the low bits of the bit buffer
  assign code_mask = (BUF_BITS'(1) << code_width_q) - BUF_BITS'(1);
  assign code_full = bit_buf_q & code_mask;
  assign code      = code_full[MaxCodeBits-1:0];

  // Sequencer: next state, datapath updates and response load
  always_comb begin
    state_d      = state_q;
    bit_buf_d    = bit_buf_q;
    bit_cnt_d    = bit_cnt_q;
    code_width_d = code_width_q;
    nfc_d        = nfc_q;
    prev_d       = prev_q;
    lit_pend_d   = lit_pend_q;
    dec_status_d = dec_status_q;
    level_d      = level_q;
    cur_d        = cur_q;
    code_d       = code_q;
    special_d    = special_q;
    first_d      = first_q;
    m_valid_d    = m_valid_q && !m_axis_tready_i;
    out_byte_d   = out_byte_q;
    out_valid_d  = out_valid_q;
    taken_d      = taken_q;
    status_d     = status_q;
    dict_raddr   = cur_q;
    dict_we      = 1'b0;
    stk_we       = 1'b0;
    stk_waddr    = level_q[MaxCodeBits-1:0];
    stk_wdata    = first_q;

    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          if (op_e'(s_axis_tuser_i[0]) == OP_PUSH) begin
            m_valid_d   = 1'b1;
            out_byte_d  = 8'd0;
            out_valid_d = 1'b0;
            taken_d     = 1'b0;
            status_d    = dec_status_q;
            if (bit_cnt_q <= BUF_CNT_W'(PUSH_LIMIT)) begin
              bit_buf_d = bit_buf_q | (BUF_BITS'(s_axis_tdata_i) << bit_cnt_q);
              bit_cnt_d = bit_cnt_q + BUF_CNT_W'(8);
              taken_d   = 1'b1;
            end
          end else if (level_q != '0) begin
            // Pop: stack read is issued this cycle
            level_d = level_dec;
            state_d = ST_POP;
          end else if (dec_status_q != STAT_RUN) begin
            m_valid_d   = 1'b1;
            out_byte_d  = 8'd0;
            out_valid_d = 1'b0;
            taken_d     = 1'b0;
            status_d    = dec_status_q;
          end else begin
            state_d = ST_DECODE;
          end
        end
      end

      ST_POP: begin
        m_valid_d   = 1'b1;
        out_byte_d  = stack_rd_q;
        out_valid_d = 1'b1;
        taken_d     = 1'b0;
        status_d    = dec_status_q;
        state_d     = ST_IDLE;
      end

      ST_DECODE: begin
        out_byte_d  = 8'd0;
        out_valid_d = 1'b0;
        taken_d     = 1'b0;
        if ((BUF_CNT_W + 1)'(bit_cnt_q) < (BUF_CNT_W + 1)'(code_width_q)) begin
          // Hold: not enough bits for a code
          m_valid_d = 1'b1;
          status_d  = STAT_NEED_BITS;
          state_d   = ST_IDLE;
        end else begin
          bit_buf_d = bit_buf_q >> code_width_q;
          bit_cnt_d = bit_cnt_q - BUF_CNT_W'(code_width_q);
          if (code == CodeClear) begin
            code_width_d = WidthStart;
            nfc_d        = FreeStart;
            lit_pend_d   = 1'b1;
          end else if (code == CodeEnd) begin
            dec_status_d = STAT_END;
            m_valid_d    = 1'b1;
            status_d     = STAT_END;
            state_d      = ST_IDLE;
          end else if (lit_pend_q) begin
            m_valid_d = 1'b1;
            state_d   = ST_IDLE;
            if (|code[MaxCodeBits-1:8]) begin
              dec_status_d = STAT_ERROR;
              status_d     = STAT_ERROR;
            end else begin
              lit_pend_d  = 1'b0;
              prev_d      = code;
              out_byte_d  = code[7:0];
              out_valid_d = 1'b1;
              status_d    = dec_status_q;
            end
          end else if (LevelW'(code) > nfc_q) begin
            dec_status_d = STAT_ERROR;
            m_valid_d    = 1'b1;
            status_d     = STAT_ERROR;
            state_d      = ST_IDLE;
          end else begin
            // Start the chain walk; the repeat case expands the previous code
            special_d  = (LevelW'(code) == nfc_q);
            code_d     = code;
            level_d    = (LevelW'(code) == nfc_q) ? LevelW'(1) : '0;
            cur_d      = (LevelW'(code) == nfc_q) ? prev_q : code;
            dict_raddr = cur_d;
            state_d    = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        // Dictionary read data belongs to cur_q
        if (|cur_q[MaxCodeBits-1:8] && !stack_full) begin
          stk_we     = 1'b1;
          stk_wdata  = suffix_rd_q;
          first_d    = suffix_rd_q;
          level_d    = level_inc;
          cur_d      = prefix_rd_q;
          dict_raddr = prefix_rd_q;
        end else begin
          if (!stack_full) begin
            stk_we    = 1'b1;
            stk_wdata = cur_q[7:0];
            first_d   = cur_q[7:0];
            level_d   = level_inc;
          end
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // Fix the repeat case, add the new entry while the dictionary has room and emit the first character
        if (special_q) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = first_q;
        end
        if (!nfc_q[MaxCodeBits]) begin
          dict_we = 1'b1;
          nfc_d   = nfc_inc;
          if ((nfc_inc >= (LevelW'(1) << code_width_q)) && (code_width_q < WidthMax)) begin
            code_width_d = code_width_q + WidthW'(1);
          end
        end
        prev_d      = code_q;
        level_d     = level_dec;
        m_valid_d   = 1'b1;
        out_byte_d  = first_q;
        out_valid_d = 1'b1;
        taken_d     = 1'b0;
        status_d    = dec_status_q;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_buf_q    <= '0;
      bit_cnt_q    <= '0;
      code_width_q <= WidthStart;
      nfc_q        <= FreeStart;
      prev_q       <= '0;
      lit_pend_q   <= 1'b0;
      dec_status_q <= STAT_RUN;
      level_q      <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      bit_buf_q    <= bit_buf_d;
      bit_cnt_q    <= bit_cnt_d;
      code_width_q <= code_width_d;
      nfc_q        <= nfc_d;
      prev_q       <= prev_d;
      lit_pend_q   <= lit_pend_d;
      dec_status_q <= dec_status_d;
      level_q      <= level_d;
      m_valid_q    <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    code_q      <= code_d;
    special_q   <= special_d;
    first_q     <= first_d;
    out_byte_q  <= out_byte_d;
    out_valid_q <= out_valid_d;
    taken_q     <= taken_d;
    status_q    <= status_d;
  end

  // Dictionary memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (dict_we) begin
      prefix_mem[nfc_q[MaxCodeBits-1:0]] <= prev_q;
      suffix_mem[nfc_q[MaxCodeBits-1:0]] <= first_q;
    end
    prefix_rd_q <= prefix_mem[dict_raddr];
    suffix_rd_q <= suffix_mem[dict_raddr];
  end

  // String stack memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stack_rd_q <= stack_mem[stk_raddr];
  end

  assign s_axis_tready_o = s_ready;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'd0, status_q, taken_q, out_valid_q, out_byte_q};

  // Stack level never passes the stack depth
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LevelW'(DictDepth))
    else $error("stack level beyond depth");

  // Code width stays within its range
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (code_width_q >= WidthStart) && (code_width_q <= WidthMax))
    else $error("code width out of range");

  // No response is pending while a request is being worked on
  a_busy_no_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !m_valid_q)
    else $error("response pending during work");

  // A pull on a filled stack goes through the pop cycle
  a_pull_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tuser_i[0] && (level_q != '0)) |=> (state_q == ST_POP))
    else $error("pull on filled stack did not pop");

endmodule

>>> sim/tb_top.sv
// Testbench for the variable width LZW decoder: generated code streams checked by prediction.
`timescale 1ns / 1ps

module tb_top;
  import lzw_vwd_pkg::*;

  localparam int unsigned DICT_DEPTH   = 1 << MAX_CODE_BITS_DEF;
  localparam int unsigned LAST_LITERAL = 'hff;
  localparam int unsigned TOP_9BIT     = (1 << START_WIDTH) - 1;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned MAX_REPORTS  = 10;

  // Ways to close the stream at the end of the run
  typedef enum logic [1:0] {
    END_BY_CODE,
    END_BAD_LITERAL,
    END_BEYOND_DICT
  } end_kind_e;

  // One decoder response, field by field
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       byte_taken;
    status_e    status;
  } dec_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'd0;   // [7:0] in_byte
  logic [0:0]  s_axis_tuser_i = 1'b0;   // [0] operation
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;          // [7:0] out_byte, [8] out_valid,
                                        // [9] byte_taken, [11:10] status

  // Predicted decoder state
  bit [MAX_CODE_BITS_DEF-1:0] link_mem [DICT_DEPTH];
  bit [7:0]    char_mem [DICT_DEPTH];
  bit [7:0]    out_stack [DICT_DEPTH];
  int unsigned out_depth = 0;
  logic [23:0] shift_reg = '0;
  int unsigned shift_cnt = 0;
  int unsigned cur_width = START_WIDTH;
  int unsigned free_code = FIRST_FREE;
  int unsigned last_code = 0;
  bit          await_literal = 1'b0;
  status_e     dec_state = STAT_RUN;

  // Encoder side: the code width and next code the decoder will use
  int unsigned enc_width = START_WIDTH;
  int unsigned enc_free = FIRST_FREE;
  bit          enc_await_lit = 1'b0;
  logic [31:0] pack_acc = '0;
  int unsigned pack_cnt = 0;
  logic [7:0]  byte_stream_q [$];

  dec_rsp_t    owed_rsp_q [$];
  int unsigned fail_cnt = 0;
  int          rx_wait = 0;
  bit          rx_hold_req = 1'b0;
  bit          no_idle = 1'b0;

  lzw_variable_width_decoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Push the string of a code onto the output stack, last character first
  function automatic void stack_string(int unsigned code);
    int unsigned cur;
    cur = code & (DICT_DEPTH - 1);
    while (cur > LAST_LITERAL && out_depth < DICT_DEPTH) begin
      out_stack[out_depth] = char_mem[cur];
      out_depth++;
      cur = link_mem[cur];
    end
    if (out_depth < DICT_DEPTH) begin
      out_stack[out_depth] = 8'(cur);
      out_depth++;
    end
  endfunction

  // Advance the predicted state by one request and return its response
  task automatic lzw_predict_response(input op_e op, input logic [7:0] din,
                                      output dec_rsp_t rsp);
    int unsigned code;
    logic [31:0] widened;
    logic [7:0]  head;
    bit          done;
    bit          starved;
    bit          kwk;
    rsp = '0;
    rsp.status = dec_state;
    starved = 1'b0;
    if (op == OP_PUSH) begin
      if (shift_cnt <= PUSH_LIMIT) begin
        widened = 32'(din) << shift_cnt;
        shift_reg = shift_reg | widened[23:0];
        shift_cnt += 8;
        rsp.byte_taken = 1'b1;
      end
    end else if (out_depth > 0) begin
      out_depth--;
      rsp.out_byte = out_stack[out_depth];
      rsp.out_valid = 1'b1;
    end else if (dec_state == STAT_RUN) begin
      done = 1'b0;
      while (!done) begin
        if (shift_cnt < cur_width) begin
          starved = 1'b1;
          done = 1'b1;
        end else begin
          code = 32'(shift_reg) & ((1 << cur_width) - 1);
          shift_reg = shift_reg >> cur_width;
          shift_cnt -= cur_width;
          if (code == CLEAR_CODE) begin
            cur_width = START_WIDTH;
            free_code = FIRST_FREE;
            await_literal = 1'b1;
          end else begin
            done = 1'b1;
            if (code == END_CODE) begin
              dec_state = STAT_END;
            end else if (await_literal) begin
              if (code > LAST_LITERAL) begin
                dec_state = STAT_ERROR;
              end else begin
                await_literal = 1'b0;
                last_code = code;
                rsp.out_byte = 8'(code);
                rsp.out_valid = 1'b1;
              end
            end else if (code > free_code) begin
              dec_state = STAT_ERROR;
            end else begin
              // A code equal to the next free one repeats the previous string
              kwk = (code == free_code);
              if (kwk) begin
                out_depth = 1;
                stack_string(last_code);
              end else begin
                out_depth = 0;
                stack_string(code);
              end
              head = out_stack[(out_depth - 1) & (DICT_DEPTH - 1)];
              if (kwk) out_stack[0] = head;
              if (free_code < DICT_DEPTH) begin
                link_mem[free_code] = last_code & (DICT_DEPTH - 1);
                char_mem[free_code] = head;
                free_code++;
                if (free_code >= (1 << cur_width) && cur_width < MAX_CODE_BITS_DEF) begin
                  cur_width++;
                end
              end
              last_code = code;
              out_depth--;
              rsp.out_byte = out_stack[out_depth];
              rsp.out_valid = 1'b1;
            end
          end
        end
      end
      rsp.status = starved ? STAT_NEED_BITS : dec_state;
    end
  endtask

  // Pack a code LSB first and track how the decoder will move along
  function automatic void append_code(int unsigned code);
    pack_acc = pack_acc | (code << pack_cnt);
    pack_cnt += enc_width;
    while (pack_cnt >= 8) begin
      byte_stream_q.push_back(pack_acc[7:0]);
      pack_acc = pack_acc >> 8;
      pack_cnt -= 8;
    end
    if (code == CLEAR_CODE) begin
      enc_width = START_WIDTH;
      enc_free = FIRST_FREE;
      enc_await_lit = 1'b1;
    end else if (enc_await_lit) begin
      enc_await_lit = 1'b0;
    end else if (code != END_CODE && enc_free < DICT_DEPTH) begin
      enc_free++;
      if (enc_free >= (1 << enc_width) && enc_width < MAX_CODE_BITS_DEF) enc_width++;
    end
  endfunction

  // Choose a valid next code; fill mode favors literals and skips clears
  function automatic int unsigned pick_code(bit fill);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (enc_await_lit) return (!fill && roll < 5) ? CLEAR_CODE : $urandom_range(0, LAST_LITERAL);
    if (!fill && roll < 4) return CLEAR_CODE;
    if (roll < (fill ? 70 : 45)) return $urandom_range(0, LAST_LITERAL);
    if (roll < (fill ? 75 : 58) && enc_free < DICT_DEPTH) return enc_free;
    if (enc_free > FIRST_FREE) return $urandom_range(FIRST_FREE, enc_free - 1);
    return $urandom_range(0, LAST_LITERAL);
  endfunction

  // Offer one request, wait for acceptance, then record its response
  task automatic send_req(input op_e op, input logic [7:0] din);
    int unsigned gap;
    dec_rsp_t    rsp;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= din;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    lzw_predict_response(op, din, rsp);
    owed_rsp_q.push_back(rsp);
  endtask

  // Hold the input until every response is back
  task automatic wait_all_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (owed_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Feed and pull just enough to decode every complete code sent so far
  task automatic drain_stream();
    bit busy;
    busy = 1'b1;
    while (busy) begin
      if (out_depth > 0) send_req(OP_PULL, 8'($urandom));
      else if (dec_state != STAT_RUN) busy = 1'b0;
      else if (shift_cnt >= cur_width) send_req(OP_PULL, 8'($urandom));
      else if (byte_stream_q.size() > 0) send_req(OP_PUSH, byte_stream_q.pop_front());
      else busy = 1'b0;
    end
  endtask

  // One random request; refused filler pushes are not counted
  task automatic traffic_step(input bit fill, output bit counted);
    bit want_pull;
    counted = 1'b1;
    while (byte_stream_q.size() < 3) append_code(pick_code(fill));
    if (out_depth > 0) want_pull = ($urandom_range(0, 4) != 0);
    else if (shift_cnt >= cur_width) want_pull = ($urandom_range(0, 9) != 0);
    else want_pull = ($urandom_range(0, 19) == 0);
    if (want_pull) begin
      send_req(OP_PULL, 8'($urandom));
    end else if (shift_cnt <= PUSH_LIMIT) begin
      send_req(OP_PUSH, byte_stream_q.pop_front());
    end else if ($urandom_range(0, 7) == 0) begin
      send_req(OP_PUSH, 8'($urandom));
      counted = 1'b0;
    end else begin
      send_req(OP_PULL, 8'($urandom));
    end
  endtask

  task automatic test_empty_pull();
    send_req(OP_PULL, 8'hff);
  endtask

  // Codes straight after reset use code zero as the prefix
  task automatic test_stream_without_clear();
    append_code(0);
    append_code(LAST_LITERAL);
    append_code(enc_free);
    append_code(FIRST_FREE);
    drain_stream();
  endtask

  // Clear, clear again, then a literal, a repeat of it and a high literal
  task automatic test_clear_codes();
    append_code(CLEAR_CODE);
    append_code(CLEAR_CODE);
    append_code(0);
    append_code(enc_free);
    append_code(LAST_LITERAL);
    drain_stream();
  endtask

  // Fill the bit buffer, then offer bytes that must be refused
  task automatic test_full_buffer();
    while (byte_stream_q.size() < 4) append_code(pick_code(1'b0));
    while (shift_cnt <= PUSH_LIMIT) send_req(OP_PUSH, byte_stream_q.pop_front());
    send_req(OP_PUSH, 8'hff);
    send_req(OP_PUSH, 8'h00);
    drain_stream();
  endtask

  task automatic test_random_traffic();
    int unsigned done_cnt;
    bit          counted;
    bit          held;
    bit          paused;
    done_cnt = 0;
    held = 1'b0;
    paused = 1'b0;
    while (done_cnt < RANDOM_ITEMS) begin
      no_idle = (done_cnt >= 100 && done_cnt < 200) || (done_cnt >= 650 && done_cnt < 750);
      // Stall the response side for a long stretch while requests keep coming
      if (!held && done_cnt >= 300) begin
        rx_hold_req = 1'b1;
        held = 1'b1;
      end
      if (!paused && done_cnt >= 550) begin
        wait_all_results();
        paused = 1'b1;
      end
      traffic_step(1'b0, counted);
      if (counted) done_cnt++;
    end
    no_idle = 1'b0;
    drain_stream();
  endtask

  // Grow the dictionary through every width up to full, keep decoding, then clear
  task automatic test_dictionary_full();
    bit counted;
    while (enc_free < DICT_DEPTH) traffic_step(1'b1, counted);
    append_code(DICT_DEPTH - 1);
    repeat (150) traffic_step(1'b1, counted);
    append_code(CLEAR_CODE);
    append_code(LAST_LITERAL);
    drain_stream();
  endtask

  // Close the stream by end code or a bad code, then check the status sticks
  task automatic test_stream_end();
    end_kind_e kind;
    kind = end_kind_e'($urandom_range(0, 2));
    drain_stream();
    case (kind)
      END_BY_CODE: begin
        append_code(END_CODE);
      end
      END_BAD_LITERAL: begin
        append_code(CLEAR_CODE);
        append_code($urandom_range(FIRST_FREE, TOP_9BIT));
      end
      default: begin
        append_code(CLEAR_CODE);
        append_code($urandom_range(0, LAST_LITERAL));
        append_code($urandom_range(FIRST_FREE + 1, TOP_9BIT));
      end
    endcase
    if (pack_cnt > 0) begin
      byte_stream_q.push_back(pack_acc[7:0]);
      pack_acc = '0;
      pack_cnt = 0;
    end
    drain_stream();
    byte_stream_q.delete();
    repeat (3) send_req(OP_PULL, 8'($urandom));
    while (shift_cnt <= PUSH_LIMIT) send_req(OP_PUSH, 8'($urandom));
    send_req(OP_PUSH, 8'hff);
    send_req(OP_PUSH, 8'h00);
    send_req(OP_PULL, 8'($urandom));
  endtask

  // Response side ready, with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_wait = LONG_HOLD;
      rx_hold_req = 1'b0;
    end
    if (rx_wait > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) rx_wait = pick_gap();
    end
  end

  // Compare each response with the oldest prediction
  always @(posedge clk_i) begin
    dec_rsp_t got;
    dec_rsp_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.out_byte   = m_axis_tdata_o[7:0];
      got.out_valid  = m_axis_tdata_o[8];
      got.byte_taken = m_axis_tdata_o[9];
      got.status     = status_e'(m_axis_tdata_o[11:10]);
      if (owed_rsp_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) begin
          $display("[%0t] response %04h with nothing outstanding", $realtime, m_axis_tdata_o);
        end
      end else begin
        want = owed_rsp_q.pop_front();
        if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
            got.byte_taken !== want.byte_taken || got.status !== want.status) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("[%0t] mismatch: byte %02h exp %02h, valid %0b exp %0b, taken %0b exp %0b, status %0d exp %0d",
                     $realtime, got.out_byte, want.out_byte, got.out_valid, want.out_valid,
                     got.byte_taken, want.byte_taken, got.status, want.status);
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_pull();
    test_stream_without_clear();
    test_clear_codes();
    test_full_buffer();
    test_random_traffic();
    test_dictionary_full();
    test_stream_end();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (owed_rsp_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (fail_cnt == 0 && owed_rsp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
